[rtl/core/dlp_pkg.sv]
package dlp_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_COMMA,
    TK_DASH,
    TK_OTHER,
    TK_END
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
  } tok_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_LEAD,
    PH_SEG
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD,
    ST_EMPTY
  } status_t;

  // up to two results written by the parser in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item0;
    out_item_t  item1;
  } res_push_t;

  localparam logic RK_DATE   = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] LEAD_MAX = 3'd4;
  localparam logic [2:0] SEG_MAX  = 3'd2;

  localparam int TOKQ_AW    = 1;
  localparam int TOKQ_DEPTH = 1 << TOKQ_AW;
  localparam int RESQ_AW    = 2;
  localparam int RESQ_DEPTH = 1 << RESQ_AW;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/core/dlp_front.sv]
module dlp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  dlp_pkg::in_item_t in_data,
  output dlp_pkg::tok_t     tok_head,
  output logic              tok_valid,
  input  logic              tok_pop
);
  import dlp_pkg::*;

  tok_t                 q_r [TOKQ_DEPTH];
  logic [TOKQ_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [TOKQ_AW:0]     cnt_r, cnt_nxt;
  tok_t                 tok_in;
  logic                 push_ok;
  logic [7:0]           dig_off;

  assign dig_off = in_data.character - CH_ZERO;

  always_comb begin
    tok_in.digit = dig_off[3:0];
    if (in_data.func) begin
      tok_in.kind = TK_END;
    end else if (in_data.character >= CH_ZERO && in_data.character <= CH_NINE) begin
      tok_in.kind = TK_DIGIT;
    end else if (in_data.character == CH_COMMA) begin
      tok_in.kind = TK_COMMA;
    end else if (in_data.character == CH_DASH) begin
      tok_in.kind = TK_DASH;
    end else begin
      tok_in.kind = TK_OTHER;
    end
  end

  assign in_full   = (cnt_r == (TOKQ_AW+1)'(TOKQ_DEPTH));
  assign push_ok   = in_push && !in_full;
  assign tok_valid = (cnt_r != '0);
  assign tok_head  = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !tok_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push_ok && tok_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (tok_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= tok_in;
    end
  end

  a_tokq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (TOKQ_AW+1)'(TOKQ_DEPTH))
    else $error("token queue count out of range");

  a_tokq_pop: assert property (@(posedge clk) disable iff (!rst_n)
    tok_pop |-> tok_valid)
    else $error("token popped from empty queue");

endmodule

[rtl/core/dlp_back.sv]
module dlp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  dlp_pkg::tok_t      tok_head,
  input  logic               tok_valid,
  output logic               tok_pop,
  input  logic               res_room,
  output dlp_pkg::res_push_t res_wr
);
  import dlp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [13:0] acc_r, acc_nxt;
  logic [3:0]  digs_r [4];
  logic [3:0]  digs_nxt [4];
  logic [6:0]  fp_r, fp_nxt, sp_r, sp_nxt;
  logic [13:0] ey_r, ey_nxt, py_r, py_nxt;
  logic        el_r, el_nxt, pl_r, pl_nxt;
  logic [3:0]  pm_r, pm_nxt;
  logic [4:0]  pd_r, pd_nxt;
  logic        cp_r, cp_nxt, any_r, any_nxt, failed_r, failed_nxt;

  // closed-run and resolved-element values
  logic [13:0] acc_mul;
  logic [4:0]  lo_sum, hi_sum;
  logic        lead_leap;
  logic        run_ok;
  logic [6:0]  fp_c, sp_c;
  logic [13:0] ey_c;
  logic        el_c;
  logic [13:0] y_e;
  logic        lp_e;
  logic [6:0]  m_e, d_e, cm, cd;
  logic        elem_ok;
  out_item_t   date_item, stat_item;
  logic        is_dig;
  logic [2:0]  limit;

  assign tok_pop = tok_valid && res_room;
  assign is_dig  = (tok_head.kind == TK_DIGIT);
  assign limit   = (phase_r == PH_LEAD) ? LEAD_MAX : SEG_MAX;
  assign acc_mul = 14'({acc_r, 3'b000} + {acc_r, 1'b0} + {10'b0, tok_head.digit});

  // leap year from the four year digits: mod 4 of a two-digit number is (2*tens+ones) mod 4
  assign lo_sum    = {digs_r[1], 1'b0} + {1'b0, digs_r[0]};
  assign hi_sum    = {digs_r[3], 1'b0} + {1'b0, digs_r[2]};
  assign lead_leap = (lo_sum[1:0] == 2'b00) &&
                     ((digs_r[1] != 4'd0 || digs_r[0] != 4'd0) || hi_sum[1:0] == 2'b00);

  always_comb begin
    fp_c   = fp_r;
    sp_c   = sp_r;
    ey_c   = ey_r;
    el_c   = el_r;
    run_ok = 1'b0;
    if (phase_r == PH_LEAD) begin
      if (cnt_r == 3'd4 && acc_r != '0) begin
        ey_c   = acc_r;
        el_c   = lead_leap;
        run_ok = 1'b1;
      end else if (cnt_r == 3'd2 && acc_r != '0) begin
        ey_c   = py_r;
        el_c   = pl_r;
        fp_c   = acc_r[6:0];
        run_ok = 1'b1;
      end
    end else if (phase_r == PH_SEG) begin
      if (cnt_r == 3'd2 && acc_r != '0) begin
        if (fp_r == '0) begin
          fp_c = acc_r[6:0];
        end else begin
          sp_c = acc_r[6:0];
        end
        run_ok = 1'b1;
      end
    end
  end

  always_comb begin
    m_e = '0;
    d_e = '0;
    priority if (fp_c != '0 && sp_c != '0) begin
      m_e = fp_c;
      d_e = sp_c;
    end else if (fp_c != '0 && pd_r != '0) begin
      d_e = fp_c;
      m_e = {3'b000, pm_r};
    end else if (fp_c != '0) begin
      m_e = fp_c;
    end else begin
      m_e = '0;
      d_e = '0;
    end
    y_e  = ey_c;
    lp_e = el_c;
    if (y_e == '0) begin
      y_e  = py_r;
      lp_e = pl_r;
    end
    if (m_e == '0) begin
      m_e = {3'b000, pm_r};
    end
    if (d_e == '0) begin
      d_e = {2'b00, pd_r};
    end
    cm = (m_e == '0) ? 7'd1 : m_e;
    cd = (d_e == '0) ? 7'd1 : d_e;
    elem_ok = (y_e != '0) && (cm <= 7'd12) &&
              (cd <= {2'b00, month_len(cm[3:0], lp_e)});
  end

  always_comb begin
    date_item.result_kind = RK_DATE;
    date_item.year        = y_e;
    date_item.month       = m_e[3:0];
    date_item.day         = d_e[4:0];
    date_item.status      = ST_OK;
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (tok_pop) begin
      if (tok_head.kind == TK_END) begin
        phase_nxt = PH_START;
      end else if (!failed_r) begin
        unique case (phase_r)
          PH_START: begin
            if (is_dig) phase_nxt = PH_LEAD;
          end
          PH_LEAD, PH_SEG: begin
            if (!is_dig && run_ok) begin
              if (tok_head.kind == TK_COMMA && elem_ok) begin
                phase_nxt = PH_START;
              end else if (tok_head.kind == TK_DASH && sp_c == '0) begin
                phase_nxt = PH_SEG;
              end
            end
          end
          default: phase_nxt = PH_START;
        endcase
      end
    end
  end

  // datapath and results
  always_comb begin
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    digs_nxt   = digs_r;
    fp_nxt     = fp_r;
    sp_nxt     = sp_r;
    ey_nxt     = ey_r;
    el_nxt     = el_r;
    py_nxt     = py_r;
    pl_nxt     = pl_r;
    pm_nxt     = pm_r;
    pd_nxt     = pd_r;
    cp_nxt     = cp_r;
    any_nxt    = any_r;
    failed_nxt = failed_r;

    stat_item.result_kind = RK_STATUS;
    stat_item.year        = '0;
    stat_item.month       = '0;
    stat_item.day         = '0;
    stat_item.status      = ST_BAD;

    res_wr.cnt   = 2'd0;
    res_wr.item0 = date_item;
    res_wr.item1 = stat_item;

    if (tok_pop) begin
      if (tok_head.kind == TK_END) begin
        priority if (failed_r) begin
          stat_item.status = ST_BAD;
        end else if (phase_r == PH_START) begin
          stat_item.status = cp_r ? ST_BAD : (any_r ? ST_OK : ST_EMPTY);
        end else if ((phase_r == PH_LEAD || phase_r == PH_SEG) && run_ok && elem_ok) begin
          stat_item.status = ST_OK;
        end else begin
          stat_item.status = ST_BAD;
        end
        if (!failed_r && (phase_r == PH_LEAD || phase_r == PH_SEG) && run_ok && elem_ok) begin
          res_wr.cnt   = 2'd2;
          res_wr.item0 = date_item;
          res_wr.item1 = stat_item;
        end else begin
          res_wr.cnt   = 2'd1;
          res_wr.item0 = stat_item;
        end
        // list done: back to power-up state, but the digit history is kept
        cnt_nxt    = '0;
        acc_nxt    = '0;
        fp_nxt     = '0;
        sp_nxt     = '0;
        ey_nxt     = '0;
        el_nxt     = 1'b0;
        py_nxt     = '0;
        pl_nxt     = 1'b0;
        pm_nxt     = '0;
        pd_nxt     = '0;
        cp_nxt     = 1'b0;
        any_nxt    = 1'b0;
        failed_nxt = 1'b0;
      end else if (!failed_r) begin
        unique case (phase_r)
          PH_START: begin
            if (is_dig) begin
              cnt_nxt     = 3'd1;
              acc_nxt     = {10'b0, tok_head.digit};
              digs_nxt[0] = tok_head.digit;
              digs_nxt[1] = '0;
              digs_nxt[2] = '0;
              digs_nxt[3] = '0;
              cp_nxt      = 1'b0;
              fp_nxt      = '0;
              sp_nxt      = '0;
              ey_nxt      = '0;
              el_nxt      = 1'b0;
            end else begin
              failed_nxt = 1'b1;
            end
          end
          PH_LEAD, PH_SEG: begin
            if (is_dig) begin
              if (cnt_r >= limit) begin
                failed_nxt = 1'b1;
              end else begin
                acc_nxt     = acc_mul;
                cnt_nxt     = cnt_r + 3'd1;
                digs_nxt[0] = tok_head.digit;
                digs_nxt[1] = digs_r[0];
                digs_nxt[2] = digs_r[1];
                digs_nxt[3] = digs_r[2];
              end
            end else if (!run_ok) begin
              failed_nxt = 1'b1;
            end else begin
              fp_nxt = fp_c;
              sp_nxt = sp_c;
              ey_nxt = ey_c;
              el_nxt = el_c;
              if (tok_head.kind == TK_COMMA) begin
                if (elem_ok) begin
                  res_wr.cnt   = 2'd1;
                  res_wr.item0 = date_item;
                  py_nxt       = y_e;
                  pl_nxt       = lp_e;
                  pm_nxt       = m_e[3:0];
                  pd_nxt       = d_e[4:0];
                  any_nxt      = 1'b1;
                  cp_nxt       = 1'b1;
                end else begin
                  failed_nxt = 1'b1;
                end
              end else if (tok_head.kind == TK_DASH && sp_c == '0) begin
                cnt_nxt = '0;
                acc_nxt = '0;
              end else begin
                failed_nxt = 1'b1;
              end
            end
          end
          default: failed_nxt = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      cnt_r    <= '0;
      acc_r    <= '0;
      digs_r   <= '{default: '0};
      fp_r     <= '0;
      sp_r     <= '0;
      ey_r     <= '0;
      el_r     <= 1'b0;
      py_r     <= '0;
      pl_r     <= 1'b0;
      pm_r     <= '0;
      pd_r     <= '0;
      cp_r     <= 1'b0;
      any_r    <= 1'b0;
      failed_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      acc_r    <= acc_nxt;
      digs_r   <= digs_nxt;
      fp_r     <= fp_nxt;
      sp_r     <= sp_nxt;
      ey_r     <= ey_nxt;
      el_r     <= el_nxt;
      py_r     <= py_nxt;
      pl_r     <= pl_nxt;
      pm_r     <= pm_nxt;
      pd_r     <= pd_nxt;
      cp_r     <= cp_nxt;
      any_r    <= any_nxt;
      failed_r <= failed_nxt;
    end
  end

  a_two_ends_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_wr.cnt == 2'd2) |-> (res_wr.item0.result_kind == RK_DATE &&
                              res_wr.item1.result_kind == RK_STATUS &&
                              tok_head.kind == TK_END))
    else $error("double result write not a date plus status");

  a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (failed_r && tok_pop && tok_head.kind != TK_END) |-> (res_wr.cnt == 2'd0))
    else $error("result written after failure");

endmodule

[rtl/core/dlp_res_queue.sv]
module dlp_res_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  dlp_pkg::res_push_t res_wr,
  output logic               res_room,
  output logic               out_empty,
  input  logic               out_pop,
  output dlp_pkg::out_item_t out_data
);
  import dlp_pkg::*;

  out_item_t          q_r [RESQ_DEPTH];
  logic [RESQ_AW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr1;
  logic [RESQ_AW:0]   cnt_r, cnt_nxt;
  logic               pop_ok;

  assign out_empty = (cnt_r == '0);
  assign pop_ok    = out_pop && !out_empty;
  assign out_data  = q_r[rd_ptr_r];
  // room for the worst case of two results in one transaction
  assign res_room  = (cnt_r <= (RESQ_AW+1)'(RESQ_DEPTH - 2));
  assign wr_ptr1   = wr_ptr_r + 1'b1;
  assign cnt_nxt   = cnt_r + (RESQ_AW+1)'(res_wr.cnt) - (RESQ_AW+1)'(pop_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + RESQ_AW'(res_wr.cnt);
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr.cnt != 2'd0) begin
      q_r[wr_ptr_r] <= res_wr.item0;
    end
    if (res_wr.cnt == 2'd2) begin
      q_r[wr_ptr1] <= res_wr.item1;
    end
  end

  a_resq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (RESQ_AW+1)'(RESQ_DEPTH))
    else $error("result queue overflow");

endmodule

[rtl/core/date_list_text_parser.sv]
// Path: an accepted transaction is written into the token queue, and the parser then writes
//   its results into the result queue, from which they can be popped.
// Throughput: one character or end transaction per cycle, set by the parser
//   handling one token per cycle; it stalls only when the result queue is near full.
// Reset: synchronous active-low rst_n empties both queues and returns the parser
//   to the start of a new list; no clearing pass.
module date_list_text_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  dlp_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output dlp_pkg::out_item_t out_data
);
  import dlp_pkg::*;

  tok_t      tok_head;
  logic      tok_valid;
  logic      tok_pop;
  logic      res_room;
  res_push_t res_wr;

  dlp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .tok_head  (tok_head),
    .tok_valid (tok_valid),
    .tok_pop   (tok_pop)
  );

  dlp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_head  (tok_head),
    .tok_valid (tok_valid),
    .tok_pop   (tok_pop),
    .res_room  (res_room),
    .res_wr    (res_wr)
  );

  dlp_res_queue u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_wr    (res_wr),
    .res_room  (res_room),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

[verif/date_list_text_parser_tb.sv]
`timescale 1ns / 100ps

module date_list_text_parser_tb;
  import dlp_pkg::*;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_t;

  // directed rows; typed rows carry the status or date that the row must end with
  localparam stim_t DIRECTED [23] = '{
    '{'{1'b1, 8'h00}, 1'b1, '{RK_STATUS, 14'd0, 4'd0, 5'd0, ST_EMPTY}},
    '{'{1'b0, "9"}, 1'b0, '0},
    '{'{1'b0, "9"}, 1'b0, '0},
    '{'{1'b0, "9"}, 1'b0, '0},
    '{'{1'b0, "9"}, 1'b0, '0},
    '{'{1'b0, CH_DASH}, 1'b0, '0},
    '{'{1'b0, "1"}, 1'b0, '0},
    '{'{1'b0, "2"}, 1'b0, '0},
    '{'{1'b0, CH_DASH}, 1'b0, '0},
    '{'{1'b0, "3"}, 1'b0, '0},
    '{'{1'b0, "1"}, 1'b0, '0},
    '{'{1'b0, CH_COMMA}, 1'b1, '{RK_DATE, 14'd9999, 4'd12, 5'd31, ST_OK}},
    '{'{1'b0, "3"}, 1'b0, '0},
    '{'{1'b0, "0"}, 1'b0, '0},
    '{'{1'b0, CH_COMMA}, 1'b0, '0},
    // trailing comma
    '{'{1'b1, 8'h00}, 1'b1, '{RK_STATUS, 14'd0, 4'd0, 5'd0, ST_BAD}},
    // one leading digit
    '{'{1'b0, "1"}, 1'b0, '0},
    '{'{1'b0, CH_DASH}, 1'b0, '0},
    '{'{1'b1, 8'h00}, 1'b1, '{RK_STATUS, 14'd0, 4'd0, 5'd0, ST_BAD}},
    // stray bytes at both ends of the byte range
    '{'{1'b0, 8'h00}, 1'b0, '0},
    '{'{1'b1, 8'h00}, 1'b1, '{RK_STATUS, 14'd0, 4'd0, 5'd0, ST_BAD}},
    '{'{1'b0, 8'hFF}, 1'b0, '0},
    '{'{1'b1, 8'hFF}, 1'b1, '{RK_STATUS, 14'd0, 4'd0, 5'd0, ST_BAD}}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_item_t  in_data = '0;
  logic      in_full;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_data;

  stim_t      stim_q[$];
  out_item_t  due_q[$];
  logic [7:0] txt_buf[$];
  int         err_cnt = 0;
  bit         feed_done = 1'b0;

  // parser state as the predictor sees it
  phase_t      prs_phase;
  logic [2:0]  dig_cnt;
  logic [13:0] dig_acc;
  logic [6:0]  pair_a, pair_b;
  logic [13:0] elem_year, prev_year;
  logic [3:0]  prev_month;
  logic [4:0]  prev_day;
  logic        comma_seen, date_seen, list_bad;

  date_list_text_parser i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void clear_parser();
    prs_phase  = PH_START;
    dig_cnt    = '0;
    dig_acc    = '0;
    pair_a     = '0;
    pair_b     = '0;
    elem_year  = '0;
    prev_year  = '0;
    prev_month = '0;
    prev_day   = '0;
    comma_seen = 1'b0;
    date_seen  = 1'b0;
    list_bad   = 1'b0;
  endfunction

  function automatic logic [4:0] days_in(logic [6:0] m, logic [13:0] y);
    logic leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      7'd2:                    days_in = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11: days_in = 5'd30;
      default:                 days_in = 5'd31;
    endcase
  endfunction

  // closes the digit run in progress; 0 when its length or value is illegal
  function automatic bit end_run();
    if (prs_phase == PH_LEAD) begin
      if (dig_cnt == 3'd4 && dig_acc != 0) begin
        elem_year = dig_acc;
        return 1'b1;
      end
      if (dig_cnt == 3'd2 && dig_acc != 0) begin
        elem_year = prev_year;
        pair_a = dig_acc[6:0];
        return 1'b1;
      end
      return 1'b0;
    end
    if (prs_phase == PH_SEG) begin
      if (dig_cnt != 3'd2 || dig_acc == 0) return 1'b0;
      if (pair_a == 0) pair_a = dig_acc[6:0];
      else pair_b = dig_acc[6:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // resolves the element against the previous date and queues it if valid
  function automatic bit emit_date();
    logic [13:0] y;
    logic [6:0]  m, d, cm, cd;
    out_item_t   r;
    y = elem_year;
    m = '0;
    d = '0;
    if (pair_a != 0 && pair_b != 0) begin
      m = pair_a;
      d = pair_b;
    end else if (pair_a != 0 && prev_day != 0) begin
      // lone pair after a full date is a day in the same month
      d = pair_a;
      m = prev_month;
    end else if (pair_a != 0) begin
      m = pair_a;
    end
    if (y == 0) y = prev_year;
    if (m == 0) m = prev_month;
    if (d == 0) d = prev_day;
    cm = (m != 0) ? m : 7'd1;
    cd = (d != 0) ? d : 7'd1;
    if (y < 1 || y > 9999 || cm > 12 || cd > days_in(cm, y)) begin
      list_bad = 1'b1;
      return 1'b0;
    end
    prev_year  = y;
    prev_month = m[3:0];
    prev_day   = d[4:0];
    date_seen  = 1'b1;
    r = '0;
    r.result_kind = RK_DATE;
    r.year  = y;
    r.month = m[3:0];
    r.day   = d[4:0];
    r.status = ST_OK;
    due_q.push_back(r);
    return 1'b1;
  endfunction

  function automatic void parse_step(in_item_t it);
    logic [7:0] c;
    logic [2:0] cap;
    logic [1:0] st;
    bit         dig;
    out_item_t  r;
    c = it.character;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    if (it.func == 1'b0) begin
      if (list_bad) return;
      case (prs_phase)
        PH_START: begin
          if (dig) begin
            prs_phase  = PH_LEAD;
            dig_cnt    = 3'd1;
            dig_acc    = 14'(c - CH_ZERO);
            comma_seen = 1'b0;
            pair_a     = '0;
            pair_b     = '0;
            elem_year  = '0;
          end else begin
            list_bad = 1'b1;
          end
        end
        PH_LEAD, PH_SEG: begin
          cap = (prs_phase == PH_LEAD) ? LEAD_MAX : SEG_MAX;
          if (dig) begin
            if (dig_cnt >= cap) begin
              list_bad = 1'b1;
            end else begin
              dig_acc = 14'(dig_acc * 10 + (c - CH_ZERO));
              dig_cnt = dig_cnt + 3'd1;
            end
          end else if (!end_run()) begin
            list_bad = 1'b1;
          end else if (c == CH_COMMA) begin
            if (emit_date()) begin
              prs_phase  = PH_START;
              comma_seen = 1'b1;
            end
          end else if (c == CH_DASH && pair_b == 0) begin
            prs_phase = PH_SEG;
            dig_cnt   = '0;
            dig_acc   = '0;
          end else begin
            list_bad = 1'b1;
          end
        end
        default: list_bad = 1'b1;
      endcase
      return;
    end
    if (list_bad) begin
      st = ST_BAD;
    end else if (prs_phase == PH_START) begin
      st = comma_seen ? ST_BAD : (date_seen ? ST_OK : ST_EMPTY);
    end else if ((prs_phase == PH_LEAD || prs_phase == PH_SEG) && end_run()) begin
      st = emit_date() ? ST_OK : ST_BAD;
    end else begin
      st = ST_BAD;
    end
    r = '0;
    r.result_kind = RK_STATUS;
    r.status = st;
    due_q.push_back(r);
    clear_parser();
  endfunction

  function automatic int pick_part();
    case ($urandom_range(9))
      0:       return $urandom_range(0, 99);
      1, 2:    return $urandom_range(28, 31);
      3:       return 2;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // appends v as w decimal digits, zero padded
  task automatic put_num(int v, int w);
    int p;
    p = 1;
    repeat (w - 1) p *= 10;
    repeat (w) begin
      txt_buf.push_back(8'(CH_ZERO + (v / p) % 10));
      p = (p > 1) ? p / 10 : 1;
    end
  endtask

  function automatic void add_item(logic f, logic [7:0] c);
    stim_t s;
    s = '0;
    s.item.func = f;
    s.item.character = c;
    stim_q.push_back(s);
  endfunction

  task automatic flag_mismatch(string msg);
    if (err_cnt < 30) $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (due_q.size() == 0) begin
      flag_mismatch($sformatf("result %h with nothing expected", got));
      return;
    end
    want = due_q.pop_front();
    if (got.result_kind !== want.result_kind)
      flag_mismatch($sformatf("kind %0d, want %0d", got.result_kind, want.result_kind));
    if (got.year !== want.year)
      flag_mismatch($sformatf("year %0d, want %0d", got.year, want.year));
    if (got.month !== want.month)
      flag_mismatch($sformatf("month %0d, want %0d", got.month, want.month));
    if (got.day !== want.day)
      flag_mismatch($sformatf("day %0d, want %0d", got.day, want.day));
    if (got.status !== want.status)
      flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
  endtask

  initial begin : main
    int n_el, nseg, w, pos, guard;
    clear_parser();
    foreach (DIRECTED[i]) stim_q.push_back(DIRECTED[i]);

    // random lists: mostly well formed, some broken on purpose
    while (stim_q.size() < 1073) begin
      txt_buf.delete();
      n_el = ($urandom_range(99) < 3) ? 0 : $urandom_range(1, 4);
      for (int e = 0; e < n_el; e++) begin
        if (e > 0) txt_buf.push_back(CH_COMMA);
        if ((e == 0 && $urandom_range(99) < 95) || $urandom_range(99) < 50) begin
          w = ($urandom_range(99) < 4) ? $urandom_range(1, 5) : 4;
          case ($urandom_range(7))
            0:       put_num(2000, w);
            1:       put_num(1900, w);
            2:       put_num(4 * $urandom_range(1, 2499), w);
            3:       put_num(9999, w);
            4:       put_num($urandom_range(0, 9), w);
            default: put_num($urandom_range(1, 9999), w);
          endcase
          nseg = ($urandom_range(99) < 4) ? 3 : $urandom_range(0, 2);
        end else begin
          put_num(pick_part(), ($urandom_range(99) < 4) ? $urandom_range(1, 3) : 2);
          nseg = ($urandom_range(99) < 4) ? 2 : $urandom_range(0, 1);
        end
        repeat (nseg) begin
          txt_buf.push_back(CH_DASH);
          put_num(pick_part(), ($urandom_range(99) < 4) ? $urandom_range(1, 3) : 2);
        end
      end
      if (txt_buf.size() != 0 && $urandom_range(99) < 15) begin
        pos = $urandom_range(txt_buf.size() - 1);
        case ($urandom_range(3))
          0:       txt_buf[pos] = 8'($urandom_range(255));
          1:       txt_buf.insert(pos, 8'(CH_ZERO + $urandom_range(9)));
          2:       txt_buf.delete(pos);
          default: txt_buf.push_back(CH_COMMA);
        endcase
      end
      foreach (txt_buf[i]) add_item(1'b0, txt_buf[i]);
      add_item(1'b1, 8'($urandom_range(255)));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (feed_done);
    guard = 0;
    while (due_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (due_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", due_q.size()));
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : feeder
    int  idx;
    bit  quiet;
    idx = 0;
    wait (rst_n);
    while (idx < stim_q.size()) begin
      @(posedge clk);
      if (in_push && !in_full) begin
        parse_step(stim_q[idx].item);
        if (stim_q[idx].typed) due_q[due_q.size() - 1] = stim_q[idx].want;
        idx++;
      end
      quiet = (idx >= 250) && (idx < 700);
      if (idx < stim_q.size() && (quiet || $urandom_range(99) >= 26)) begin
        in_push <= 1'b1;
        in_data <= stim_q[idx].item;
      end else begin
        in_push <= 1'b0;
      end
    end
    feed_done = 1'b1;
  end

  initial begin : drain
    int hold, popped;
    hold = 0;
    popped = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        check_result(out_data);
        popped++;
        // one long back-pressure window so the input side fills and stalls
        if (popped == 60) hold = 150;
      end
      if (hold > 0) begin
        hold--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= (popped >= 90 && popped < 140) || ($urandom_range(99) >= 26);
      end
    end
  end

endmodule
